/* rtl/rwc_pkg.sv */
// Package: shared types, constants and helpers for the RGB window convolution.
package rwc_pkg;
    localparam int MaxWidth = 1024;
    localparam int KernelMax = 3;
    localparam int CoeffFracBits = 12;
    localparam int ColW = $clog2(MaxWidth);
    localparam int RowW = 12;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 48;

    localparam logic [CfgIdxW-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_KROWS  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_KCOLS  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_COEF0  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_COEF1  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_COEF2  = 3'd6;

    typedef logic [23:0] t_pix;

    typedef struct packed {
        logic            start_of_frame;
        logic [7:0]      chan_zero;
        logic [7:0]      chan_one;
        logic [7:0]      chan_two;
    } t_in;

    typedef struct packed {
        logic [RowW-1:0] out_row;
        logic [9:0]      out_col;
        logic            filtered;
        logic [7:0]      res_zero;
        logic [7:0]      res_one;
        logic [7:0]      res_two;
        logic            last_of_run;
    } t_out;

    // lane control passed from window stage to merge
    typedef struct packed {
        logic            filt;
        logic            pass;
        logic [RowW-1:0] frow;
        logic [9:0]      fcol;
        logic [RowW-1:0] prow;
        logic [9:0]      pcol;
        t_pix            pix;
    } t_ctl;

    function automatic logic [7:0] sat_sum(input logic signed [31:0] s);
        logic [31:0] v;
        begin
            v = 32'(s) >> CoeffFracBits;
            if (s <= 0) sat_sum = 8'd0;
            else if (v > 32'd255) sat_sum = 8'd255;
            else sat_sum = v[7:0];
        end
    endfunction
endpackage

/* rtl/rwc_stream_if.sv */
// Interface: valid/ready channel carrying one beat of a packed payload.
interface rwc_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/rgb_window_convolution.sv */
// Top level: RGB 3x3 window convolution over a raster pixel stream.
//  channel   dir  payload
//  s_pix     in   start_of_frame, chan_zero/one/two
//  m_res     out  out_row, out_col, filtered, res_*, last_of_run
//  cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
// One pixel per clock while the pipeline advances. A beat moves line-store read -> window ->
// product -> sum stages into a 4-entry result buffer; results are presented
// from the buffer's registered slots.
// The pipeline advances while the sum stage is empty or the buffer has room for two
// results (2 slots); with an open sink the buffer holds one entry and never stalls.
// Reset is synchronous; line stores are not cleared.
module rgb_window_convolution (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rwc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [rwc_pkg::CfgDataW-1:0] i_cfg_data,
    rwc_stream_if.sink                   s_pix,
    rwc_stream_if.source                 m_res
);
    import rwc_pkg::*;
    logic [10:0] r_w; logic [11:0] r_h; logic [1:0] r_kr, r_kc;
    logic [47:0] r_coef [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 11'd640; r_h <= 12'd480; r_kr <= 2'd1; r_kc <= 2'd1;
            r_coef[0] <= 48'd4096; r_coef[1] <= '0; r_coef[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:  r_w <= i_cfg_data[10:0];
                REG_HEIGHT: r_h <= i_cfg_data[11:0];
                REG_KROWS:  r_kr <= i_cfg_data[1:0];
                REG_KCOLS:  r_kc <= i_cfg_data[1:0];
                REG_COEF0:  r_coef[0] <= i_cfg_data;
                REG_COEF1:  r_coef[1] <= i_cfg_data;
                REG_COEF2:  r_coef[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline: stage0 line read, stage1 window, stage2 products, stage3 sums
    logic r_v0, r_v1, r_v2, r_v3;
    t_ctl r_c2, r_c3, c1;
    t_pix win [3][3];
    logic adv;
    // result buffer, 4 slots
    t_out r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    // a beat leaving the sum stage pushes at most one result, as filt and pass exclude each other; 2 slots are reserved
    assign adv = !r_v3 || (r_cnt <= 3'd2);
    logic take;
    assign s_pix.ready = adv;
    assign take = s_pix.valid & adv;

    rwc_window u_win (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(take), .i_adv(adv), .i_va(r_v0),
        .i_in(t_in'(s_pix.data)),
        .i_w(r_w), .i_h(r_h), .i_kr(r_kr), .i_kc(r_kc), .o_win(win), .o_ctl(c1)
    );

    // kernel select: coefficient (i,j) pairs with window[kr-1-i][3-kc+j]
    logic [1:0] kr, kc;
    assign kr = (r_kr == 0) ? 2'd1 : r_kr;
    assign kc = (r_kc == 0) ? 2'd1 : r_kc;
    logic [8:0][15:0] kv;
    logic [8:0][7:0] p0, p1, p2;
    always_comb begin
        for (int d = 0; d < 3; d++)
            for (int c = 0; c < 3; c++) begin
                // i = kr-1-d, j = c-3+kc; unused taps see zero pixels too
                if ((d < int'(kr)) && (c + int'(kc) >= 3)) begin
                    p0[d*3+c] = win[d][c][7:0];
                    p1[d*3+c] = win[d][c][15:8];
                    p2[d*3+c] = win[d][c][23:16];
                    kv[d*3+c] = r_coef[2'(int'(kr) - 1 - d)][16*(c + int'(kc) - 3) +: 16];
                end else begin
                    p0[d*3+c] = '0;
                    p1[d*3+c] = '0;
                    p2[d*3+c] = '0;
                    kv[d*3+c] = '0;
                end
            end
    end

    logic [7:0] q0, q1, q2;
    rwc_lane u_l0 (.i_clk(i_clk), .i_en(adv), .i_px(p0), .i_k(kv), .o_res(q0));
    rwc_lane u_l1 (.i_clk(i_clk), .i_en(adv), .i_px(p1), .i_k(kv), .o_res(q1));
    rwc_lane u_l2 (.i_clk(i_clk), .i_en(adv), .i_px(p2), .i_k(kv), .o_res(q2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
        end else if (adv) begin
            r_v0 <= take; r_v1 <= r_v0; r_v2 <= r_v1; r_v3 <= r_v2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c2 <= c1; r_c3 <= r_c2;
        end
    end

    // merge: push filtered then passthrough result
    t_out fo, po;
    logic pushf, pushp, pop;
    always_comb begin
        fo = '{out_row: r_c3.frow, out_col: r_c3.fcol, filtered: 1'b1,
               res_zero: q0, res_one: q1, res_two: q2, last_of_run: !r_c3.pass};
        po = '{out_row: r_c3.prow, out_col: r_c3.pcol, filtered: 1'b0,
               res_zero: r_c3.pix[7:0], res_one: r_c3.pix[15:8],
               res_two: r_c3.pix[23:16], last_of_run: 1'b1};
        pushf = adv & r_v3 & r_c3.filt;
        pushp = adv & r_v3 & r_c3.pass;
    end
    assign pop = m_res.valid & m_res.ready;
    always_ff @(posedge i_clk) begin
        if (pushf) r_q[r_wp] <= fo;
        if (pushp) r_q[pushf ? r_wp + 2'd1 : r_wp] <= po;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp <= r_wp + 2'(pushf) + 2'(pushp);
            r_rp <= r_rp + 2'(pop);
            r_cnt <= r_cnt + 3'(pushf) + 3'(pushp) - 3'(pop);
        end
    end
    assign m_res.valid = (r_cnt != 0);
    assign m_res.data = r_q[r_rp];

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 3'd4)
        else $error("result buffer overflow");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 0) |-> !m_res.valid) else $error("valid with empty buffer");
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pushf && !pushp) |-> fo.last_of_run) else $error("run end missing");
endmodule

/* rtl/rwc_lane.sv */
// Lane: one channel, nine products summed over a two-stage pipeline.
module rwc_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [8:0][7:0]             i_px,
    input  logic [8:0][15:0]            i_k,
    output logic [7:0]                  o_res
);
    import rwc_pkg::*;
    logic signed [24:0] r_prod [9];
    logic [7:0]         r_res;
    logic signed [31:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 9; i++)
                r_prod[i] <= $signed({1'b0, i_px[i]}) * $signed(i_k[i]);
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < 9; i++) n_sum = n_sum + 32'(r_prod[i]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_res <= sat_sum(n_sum);
    end
    assign o_res = r_res;
endmodule

/* rtl/rwc_window.sv */
// Window: position tracking, line stores and 3x3 window shift.
module rwc_window (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_adv,
    input  logic                   i_va,
    input  rwc_pkg::t_in           i_in,
    input  logic [10:0]            i_w,
    input  logic [11:0]            i_h,
    input  logic [1:0]             i_kr,
    input  logic [1:0]             i_kc,
    output rwc_pkg::t_pix          o_win [3][3],
    output rwc_pkg::t_ctl          o_ctl
);
    import rwc_pkg::*;
    // both line stores in one word per column: {older row, newer row}
    logic [47:0] r_lines [MaxWidth];
    logic [47:0] r_rd;
    logic [9:0]  r_xa;
    t_pix        r_pixa;
    t_pix r_win [3][3];
    logic [9:0]  r_col;
    logic [11:0] r_row;
    t_ctl r_ctla, r_ctl;
    logic [12:0] w, h, x, y, kr, kc, xn, yn;
    t_pix pix;

    always_comb begin
        w = (i_w == 0) ? 13'd1 : (i_w > 11'(MaxWidth)) ? 13'(MaxWidth) : 13'(i_w);
        h = (i_h == 0) ? 13'd1 : 13'(i_h);
        kr = (i_kr == 0) ? 13'd1 : 13'(i_kr);
        kc = (i_kc == 0) ? 13'd1 : 13'(i_kc);
        x = i_in.start_of_frame ? 13'd0 : 13'(r_col);
        y = i_in.start_of_frame ? 13'd0 : 13'(r_row);
        if (x >= w) begin
            x = 0; y = y + 1;
        end
        if (y >= h) y = 0;
        pix = {i_in.chan_two, i_in.chan_one, i_in.chan_zero};
        xn = x + 1; yn = y;
        if (xn >= w) begin
            xn = 0; yn = y + 1;
            if (yn >= h) yn = 0;
        end
    end

    // line stores: registered read at accept, write-back one stage later;
    // a back-to-back beat at the same column takes the pending write-back
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_va && (r_xa == x[9:0])) r_rd <= {r_rd[23:0], r_pixa};
            else r_rd <= r_lines[x[9:0]];
            r_xa   <= x[9:0];
            r_pixa <= pix;
        end
        if (i_adv && i_va) r_lines[r_xa] <= {r_rd[23:0], r_pixa};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0;
        end else if (i_en) begin
            r_col <= xn[9:0]; r_row <= yn[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < 3; d++)
                for (int c = 0; c < 3; c++) r_win[d][c] <= '0;
        end else if (i_adv && i_va) begin
            for (int d = 0; d < 3; d++) begin
                r_win[d][0] <= r_win[d][1];
                r_win[d][1] <= r_win[d][2];
            end
            r_win[0][2] <= r_pixa;
            r_win[1][2] <= r_rd[23:0];
            r_win[2][2] <= r_rd[47:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctla.filt <= (y + 1 >= kr) && (x + 1 >= kc) && (y + kr <= h) && (x + kc <= w);
            r_ctla.pass <= (y + kr > h) || (x + kc > w);
            r_ctla.frow <= 12'(y + 1 - kr);
            r_ctla.fcol <= 10'(x + 1 - kc);
            r_ctla.prow <= y[11:0];
            r_ctla.pcol <= x[9:0];
            r_ctla.pix  <= pix;
        end
        if (i_adv) r_ctl <= r_ctla;
    end

    always_comb begin
        for (int d = 0; d < 3; d++)
            for (int c = 0; c < 3; c++) o_win[d][c] = r_win[d][c];
    end
    assign o_ctl = r_ctl;
endmodule
